/* rtl/upc_pkg.sv */
// Package for the URI percent codec: item types, character constants and
// the small character-class functions shared by the front and back parts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package upc_pkg;

  // Configuration port geometry and register indexes
  localparam int unsigned UPC_PADDR_W     = 3;
  localparam int unsigned UPC_PDATA_W     = 32;
  localparam logic        UPC_REG_DECODE_MODE = 1'b0;

  // Default depth of the command queue between front and back
  localparam int unsigned UPC_QUEUE_DEPTH = 2;

  // Characters of interest
  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [3:0] NIBBLE_MASK = 4'h0F;

  // Input and result items
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } upc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } upc_out_t;

  // One classified item: one to three result bytes, emitted from index 0
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } upc_cmd_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } upc_qstat_t;

  // Result of a hex digit lookup
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } upc_hex_t;

  // Escape sequence decoder state
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upc_phase_e;

  // Uppercase hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

  // Hex digit value of a character, either case; 0xFF is never a digit
  function automatic upc_hex_t hex_value(input logic [7:0] c);
    upc_hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  // Bytes that pass through the encoder unchanged
  function automatic logic is_safe(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == DOT_CHAR);
  endfunction

endpackage

`default_nettype wire

/* rtl/upc_front.sv */
// Front part of the URI percent codec: accepts input items, classifies
// them, keeps the escape decoder state and pushes commands to the queue.
// Depends on upc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire upc_pkg::upc_in_t   in_item_i,
  output logic                    in_stall_o,
  input  wire logic               decode_mode_i,
  input  wire logic               clear_i,
  input  wire upc_pkg::upc_qstat_t q_stat_i,
  output logic                    push_o,
  output upc_pkg::upc_cmd_t       push_cmd_o
);

  upc_pkg::upc_phase_e phase_q, phase_d;
  logic [7:0]          held_q, held_d;
  upc_pkg::upc_cmd_t   cmd;
  upc_pkg::upc_hex_t   hv_b, hv_held;
  logic [7:0]          b;
  logic                last;
  logic                accept;
  logic                pct_cont;

  assign b          = in_item_i.data_byte;
  assign last       = in_item_i.end_of_string;
  assign hv_b       = upc_pkg::hex_value(b);
  assign hv_held    = upc_pkg::hex_value(held_q);
  assign pct_cont   = (b == upc_pkg::PCT_CHAR) && !last;
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    cmd      = '0;
    cmd.last = last;
    phase_d  = phase_q;
    held_d   = held_q;
    if (!decode_mode_i) begin
      if (upc_pkg::is_safe(b)) begin
        cmd.bytes[0] = b;
        cmd.cnt      = 2'd1;
      end else begin
        cmd.bytes[0] = upc_pkg::PCT_CHAR;
        cmd.bytes[1] = upc_pkg::hex_char(b[7:4]);
        cmd.bytes[2] = upc_pkg::hex_char(b[3:0] & upc_pkg::NIBBLE_MASK);
        cmd.cnt      = 2'd3;
      end
    end else begin
      case (phase_q)
        upc_pkg::PH_PCT: begin
          if (hv_b.ok && !last) begin
            held_d  = b;
            phase_d = upc_pkg::PH_DIGIT;
          end else begin
            cmd.bytes[0] = upc_pkg::PCT_CHAR;
            if (pct_cont) begin
              cmd.cnt = 2'd1;
            end else begin
              cmd.bytes[1] = b;
              cmd.cnt      = 2'd2;
              phase_d      = upc_pkg::PH_IDLE;
            end
          end
        end
        upc_pkg::PH_DIGIT: begin
          held_d = '0;
          if (hv_b.ok) begin
            cmd.bytes[0] = {hv_held.val, hv_b.val};
            cmd.cnt      = 2'd1;
            phase_d      = upc_pkg::PH_IDLE;
          end else begin
            cmd.bytes[0] = upc_pkg::PCT_CHAR;
            cmd.bytes[1] = held_q;
            if (pct_cont) begin
              cmd.cnt = 2'd2;
              phase_d = upc_pkg::PH_PCT;
            end else begin
              cmd.bytes[2] = b;
              cmd.cnt      = 2'd3;
              phase_d      = upc_pkg::PH_IDLE;
            end
          end
        end
        default: begin
          if (pct_cont) begin
            phase_d = upc_pkg::PH_PCT;
          end else begin
            cmd.bytes[0] = b;
            cmd.cnt      = 2'd1;
            phase_d      = upc_pkg::PH_IDLE;
          end
        end
      endcase
    end
    // End of string: drop anything held
    if (last) begin
      phase_d = upc_pkg::PH_IDLE;
      held_d  = '0;
    end
  end

  assign push_o     = accept && (cmd.cnt != 2'd0);
  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upc_pkg::PH_IDLE;
      held_q  <= '0;
    end else if (clear_i) begin
      phase_q <= upc_pkg::PH_IDLE;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

`ifndef NO_ASSERTIONS
  // Encode mode never leaves the decoder holding anything
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !decode_mode_i |=> (phase_q == upc_pkg::PH_IDLE) || $past(decode_mode_i))
    else $error("decoder state left in encode mode");

  // A digit is held only after a held percent sign
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == upc_pkg::PH_DIGIT) && !$past(phase_q == upc_pkg::PH_DIGIT) |->
      $past(phase_q == upc_pkg::PH_PCT))
    else $error("hex digit held without percent sign");

  // An item marked last always produces a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |-> push_o)
    else $error("last item produced no result");
`endif

endmodule

`default_nettype wire

/* rtl/upc_queue.sv */
// Short command queue between the front and back parts of the URI percent
// codec. Depends on upc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upc_queue #(
  parameter int unsigned DEPTH = upc_pkg::UPC_QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire upc_pkg::upc_cmd_t  push_cmd_i,
  input  wire logic               pop_i,
  output upc_pkg::upc_cmd_t       head_o,
  output upc_pkg::upc_qstat_t     stat_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  upc_pkg::upc_cmd_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_o.empty |-> (head_o.cnt != 2'd0))
    else $error("empty command at queue head");
`endif

endmodule

`default_nettype wire

/* rtl/upc_back.sv */
// Back part of the URI percent codec: emits the bytes of the command at the
// queue head one per cycle unless out_stall_i is high, and pops it after its
// final byte. Depends on upc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upc_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire upc_pkg::upc_cmd_t   head_i,
  input  wire upc_pkg::upc_qstat_t q_stat_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output upc_pkg::upc_out_t        out_item_o
);

  logic [1:0] idx_q;
  logic       final_byte;
  logic       take;

  assign out_valid_o = !q_stat_i.empty;
  assign final_byte  = (idx_q == head_i.cnt - 2'd1);
  assign take        = out_valid_o && !out_stall_i;
  assign pop_o       = take && final_byte;

  always_comb begin
    case (idx_q)
      2'd0:    out_item_o.out_byte = head_i.bytes[0];
      2'd1:    out_item_o.out_byte = head_i.bytes[1];
      default: out_item_o.out_byte = head_i.bytes[2];
    endcase
    out_item_o.out_last = head_i.last && final_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < head_i.cnt))
    else $error("byte index beyond command length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(idx_q))
    else $error("byte index moved while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat_i.empty |-> (idx_q == 2'd0))
    else $error("partial command left on empty queue");
`endif

endmodule

`default_nettype wire

/* rtl/uri_percent_codec_unit.sv */
// URI percent codec, top level: configuration port, front part, command
// queue and back part. Depends on upc_pkg, upc_front, upc_queue, upc_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one source byte
//   an item, with end_of_string on the final byte of a string. Output channel
//   (out_valid_o / out_stall_i / out_item_o) gives one result byte an item,
//   out_last marking the final byte of the string.
//   decode_mode (APB byte address 0, bit 0) selects encode (0) or decode (1);
//   writing it discards any held escape bytes. Write it only when idle.
//   An accepted item's command is registered in the queue; its bytes are
//   offered from the queue head one byte a cycle while out_stall_i is low,
//   so an item with three results (an escape in encode mode, a broken
//   escape in decode mode) holds the output for all three bytes. In decode
//   mode a held percent sign or first hex digit gives no result at once.
//   Throughput: one input item a cycle while out_stall_i is low and each item
//   yields at most one byte; otherwise set by the single-byte output port. A
//   queue of QueueDepth commands decouples the sides; the input stalls only
//   when it is full, so the input keeps flowing while a result waits to be
//   taken. Reset: queue empty, encode mode, nothing held. While out_stall_i
//   is high the offered byte holds, the queue fills, then in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none

module uri_percent_codec_unit #(
  parameter int unsigned QueueDepth = upc_pkg::UPC_QUEUE_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire upc_pkg::upc_in_t                  in_item_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output upc_pkg::upc_out_t                      out_item_o,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [upc_pkg::UPC_PADDR_W-1:0]   paddr,
  input  wire logic [upc_pkg::UPC_PDATA_W-1:0]   pwdata,
  output logic [upc_pkg::UPC_PDATA_W-1:0]        prdata,
  output logic                                   pready
);

  logic                decode_mode_q;
  logic                cfg_wr;
  logic                reg_hit;
  logic                push;
  logic                pop;
  upc_pkg::upc_cmd_t   push_cmd;
  upc_pkg::upc_cmd_t   head;
  upc_pkg::upc_qstat_t q_stat;

  // Register decode on the word index; low byte-address bits are ignored
  assign reg_hit = (paddr[upc_pkg::UPC_PADDR_W-1:2] == upc_pkg::UPC_REG_DECODE_MODE);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(upc_pkg::UPC_PDATA_W-1){1'b0}}, decode_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      decode_mode_q <= pwdata[0];
    end
  end

  // Classify items and track escape state
  upc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .decode_mode_i(decode_mode_q),
    .clear_i      (cfg_wr),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  // Hold classified commands until the back part drains them
  upc_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (head),
    .stat_o    (q_stat)
  );

  // Emit result bytes one a cycle while out_stall_i is low
  upc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

`ifndef NO_ASSERTIONS
  // A last byte always closes its command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_item_o.out_last |-> pop)
    else $error("last byte without command pop");

  // The input stalls only because the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_stat.full)
    else $error("input stalled with queue space");

  // Configuration write leaves the mode register as written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> decode_mode_q == $past(pwdata[0]))
    else $error("mode register not updated");
`endif

endmodule

`default_nettype wire
